// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- rtl/ghl_pkg.sv -----
package ghl_pkg;

   localparam int ID_BITS_DEFAULT = 32;
   localparam int GOAL_ID_BITS    = 32;
   localparam int SEQ_BITS        = 64;
   localparam int TAG_BITS        = 8;
   localparam int NUM_STATES      = 12;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_WAITING    = 4'd1,
      ST_SENDING    = 4'd2,
      ST_ACCEPTED   = 4'd3,
      ST_EXECUTING  = 4'd4,
      ST_CANCELING  = 4'd5,
      ST_SUCCEEDED  = 4'd6,
      ST_REJECTED   = 4'd7,
      ST_ABORTED    = 4'd8,
      ST_CANCELED   = 4'd9,
      ST_TIMED_OUT  = 4'd10,
      ST_ERROR      = 4'd11
   } life_state_type;

   typedef enum logic [3:0] {
      OP_BEGIN            = 4'd0,
      OP_SERVER_AVAILABLE = 4'd1,
      OP_ACCEPTED         = 4'd2,
      OP_EXECUTING        = 4'd3,
      OP_CANCEL           = 4'd4,
      OP_SUCCEEDED        = 4'd5,
      OP_REJECTED         = 4'd6,
      OP_ABORTED          = 4'd7,
      OP_CANCELED         = 4'd8,
      OP_TIMED_OUT        = 4'd9,
      OP_ERROR            = 4'd10,
      OP_RESET            = 4'd11
   } op_type;

   typedef enum logic [4:0] {
      RC_TAG              = 5'd0,
      RC_ID_EMPTY         = 5'd1,
      RC_ALREADY_ACTIVE   = 5'd2,
      RC_GOAL_RECEIVED    = 5'd3,
      RC_SERVER_AVAILABLE = 5'd4,
      RC_GOAL_ACCEPTED    = 5'd5,
      RC_GOAL_EXECUTING   = 5'd6,
      RC_CANCEL_BEFORE    = 5'd7,
      RC_CANCEL_REQUESTED = 5'd8,
      RC_GOAL_SUCCEEDED   = 5'd9,
      RC_GOAL_REJECTED    = 5'd10,
      RC_GOAL_ABORTED     = 5'd11,
      RC_GOAL_CANCELED    = 5'd12,
      RC_GOAL_TIMED_OUT   = 5'd13,
      RC_HANDOFF_ERROR    = 5'd14,
      RC_ALREADY_IDLE     = 5'd15,
      RC_NO_RESET         = 5'd16,
      RC_IDLE             = 5'd17,
      RC_INVALID          = 5'd18
   } reason_type;

   // bit t of row f: step f -> t is legal
   localparam logic [NUM_STATES-1:0] ALLOW_ROW [NUM_STATES] = '{
      12'b1000_0000_0010,
      12'b1110_1000_0100,
      12'b1110_1000_1000,
      12'b1111_0111_0000,
      12'b1111_0110_0000,
      12'b1111_0100_0000,
      12'b0000_0000_0011,
      12'b0000_0000_0011,
      12'b0000_0000_0011,
      12'b0000_0000_0011,
      12'b0000_0000_0011,
      12'b0000_0000_0011
   };

   typedef struct packed {
      life_state_type            life_state;
      logic [GOAL_ID_BITS-1:0]   held_id;
      logic [SEQ_BITS-1:0]       seq;
      reason_type                last_code;
      logic [TAG_BITS-1:0]       last_tag;
   } ctx_type;

   typedef struct packed {
      logic                      accepted_ok;
      logic [3:0]                prev_state;
      logic [3:0]                new_state;
      logic [GOAL_ID_BITS-1:0]   current_goal_id;
      logic [SEQ_BITS-1:0]       goal_sequence;
      logic [4:0]                reason_code;
      logic [TAG_BITS-1:0]       reason_tag;
   } rsp_type;

   function automatic logic step_allowed(life_state_type from_st, life_state_type to_st);
      logic [NUM_STATES-1:0] row;
      row = ALLOW_ROW[from_st];
      return (from_st == to_st) || row[to_st];
   endfunction

   function automatic logic goal_in_flight(life_state_type st);
      return (st >= ST_WAITING) && (st <= ST_CANCELING);
   endfunction

   function automatic logic goal_finished(life_state_type st);
      return (st >= ST_SUCCEEDED) && (st <= ST_ERROR);
   endfunction

endpackage

// ----- rtl/ghl_req_if.sv -----
interface ghl_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic [31:0] goal_id;
   logic [7:0]  caller_reason;

   modport source (output valid, output op, output goal_id, output caller_reason,
                   input ready);
   modport sink   (input valid, input op, input goal_id, input caller_reason,
                   output ready);
endinterface

// ----- rtl/ghl_rsp_if.sv -----
interface ghl_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted_ok;
   logic [3:0]  prev_state;
   logic [3:0]  new_state;
   logic [31:0] current_goal_id;
   logic [63:0] goal_sequence;
   logic [4:0]  reason_code;
   logic [7:0]  reason_tag;

   modport source (output valid, output accepted_ok, output prev_state, output new_state,
                   output current_goal_id, output goal_sequence, output reason_code,
                   output reason_tag, input ready);
   modport sink   (input valid, input accepted_ok, input prev_state, input new_state,
                   input current_goal_id, input goal_sequence, input reason_code,
                   input reason_tag, output ready);
endinterface

// ----- rtl/goal_handoff_lifecycle_fsm_top.sv -----
// Goal hand-off lifecycle machine.
// req channel: one transaction per lifecycle event (op, goal_id, caller_reason).
// rsp channel: exactly one transaction per event, in order: accepted_ok,
//   prev_state, new_state, current_goal_id, goal_sequence, reason_code,
//   reason_tag.
// Path: an event accepted on req is captured in the input register; when it
//   advances it is checked against the transition table and applied to the
//   lifecycle state, and its result is stored in the result register, which
//   presents it on rsp until the receiver takes it.
// Throughput: one event per cycle while rsp is not stalled; the only loop is
//   the table check and update of the lifecycle state register.
// Stall: while a result waits on rsp, one further event is still taken into
//   the input register; req.ready then drops until rsp moves again.
// Reset (synchronous, active high): state idle, stored id 0, sequence 0,
//   both stages empty. No clearing pass; events are taken the cycle after.
// ID_BITS: number of low goal_id bits that are kept; values above 32 keep all 32.
module goal_handoff_lifecycle_fsm_top #(
   parameter int ID_BITS = ghl_pkg::ID_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ghl_req_if.sink    req,
   ghl_rsp_if.source  rsp
);
   import ghl_pkg::*;
   `include "assert_macros.svh"

   logic                    in_valid_ff;
   logic [3:0]              op_ff;
   logic [GOAL_ID_BITS-1:0] gid_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   ctx_type                 ctx_ff;
   ctx_type                 ctx_in;
   logic                    out_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    advance;
   logic                    take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !reset && (!in_valid_ff || advance);
   assign take      = req.valid && req.ready;

   ghl_step #(
      .ID_BITS (ID_BITS)
   ) u_step (
      .ctx           (ctx_ff),
      .op            (op_ff),
      .goal_id       (gid_ff),
      .caller_reason (tag_ff),
      .ctx_next      (ctx_in),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (take) begin
         op_ff  <= req.op;
         gid_ff <= req.goal_id;
         tag_ff <= req.caller_reason;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.life_state <= ST_IDLE;
         ctx_ff.held_id    <= '0;
         ctx_ff.seq        <= '0;
         ctx_ff.last_code  <= RC_IDLE;
         ctx_ff.last_tag   <= '0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.accepted_ok     = rsp_ff.accepted_ok;
   assign rsp.prev_state      = rsp_ff.prev_state;
   assign rsp.new_state       = rsp_ff.new_state;
   assign rsp.current_goal_id = rsp_ff.current_goal_id;
   assign rsp.goal_sequence   = rsp_ff.goal_sequence;
   assign rsp.reason_code     = rsp_ff.reason_code;
   assign rsp.reason_tag      = rsp_ff.reason_tag;

   `ASSERT_NEXT(a_refused_keeps_ctx, clock, reset,
      advance && !rsp_in.accepted_ok, ctx_ff == $past(ctx_ff))
   `ASSERT_NEXT(a_reason_recorded, clock, reset,
      advance && rsp_in.accepted_ok && !(op_ff == OP_RESET && ctx_ff.life_state == ST_IDLE),
      ctx_ff.last_code == $past(rsp_in.reason_code) && ctx_ff.last_tag == $past(rsp_in.reason_tag))
   `ASSERT_IMPLIES(a_move_needs_ok, clock, reset,
      out_valid_ff && rsp_ff.new_state != rsp_ff.prev_state, rsp_ff.accepted_ok)
   `ASSERT_NEXT(a_seq_steps_by_one, clock, reset, advance,
      ctx_ff.seq == $past(ctx_ff.seq) || ctx_ff.seq == $past(ctx_ff.seq) + SEQ_BITS'(1))

endmodule

// ----- rtl/ghl_step.sv -----
module ghl_step #(
   parameter int ID_BITS = ghl_pkg::ID_BITS_DEFAULT
) (
   input  ghl_pkg::ctx_type                    ctx,
   input  logic [3:0]                          op,
   input  logic [ghl_pkg::GOAL_ID_BITS-1:0]    goal_id,
   input  logic [ghl_pkg::TAG_BITS-1:0]        caller_reason,
   output ghl_pkg::ctx_type                    ctx_next,
   output ghl_pkg::rsp_type                    rsp
);
   import ghl_pkg::*;

   localparam int KEEP_BITS = (ID_BITS < GOAL_ID_BITS) ? ID_BITS : GOAL_ID_BITS;
   localparam logic [GOAL_ID_BITS-1:0] ID_MASK =
      {GOAL_ID_BITS{1'b1}} >> (GOAL_ID_BITS - KEEP_BITS);

   logic [GOAL_ID_BITS-1:0] gid;
   life_state_type          prev;
   life_state_type          target;
   reason_type              code;
   logic [TAG_BITS-1:0]     rtag;
   logic                    ok;
   logic                    uses_tag;
   logic                    keep_reason;

   assign gid  = goal_id & ID_MASK;
   assign prev = ctx.life_state;

   always_comb begin
      target   = prev;
      code     = RC_INVALID;
      uses_tag = 1'b0;
      unique case (op) inside
         OP_SERVER_AVAILABLE: begin target = ST_SENDING;   code = RC_SERVER_AVAILABLE; end
         OP_ACCEPTED:         begin target = ST_ACCEPTED;  code = RC_GOAL_ACCEPTED;    end
         OP_EXECUTING:        begin target = ST_EXECUTING; code = RC_GOAL_EXECUTING;   end
         OP_CANCEL: begin
            target = ST_CANCELING; code = RC_CANCEL_REQUESTED; uses_tag = 1'b1;
         end
         OP_SUCCEEDED:        begin target = ST_SUCCEEDED; code = RC_GOAL_SUCCEEDED;   end
         OP_REJECTED: begin
            target = ST_REJECTED;  code = RC_GOAL_REJECTED;  uses_tag = 1'b1;
         end
         OP_ABORTED: begin
            target = ST_ABORTED;   code = RC_GOAL_ABORTED;   uses_tag = 1'b1;
         end
         OP_CANCELED: begin
            target = ST_CANCELED;  code = RC_GOAL_CANCELED;  uses_tag = 1'b1;
         end
         OP_TIMED_OUT: begin
            target = ST_TIMED_OUT; code = RC_GOAL_TIMED_OUT; uses_tag = 1'b1;
         end
         OP_ERROR: begin
            target = ST_ERROR;     code = RC_HANDOFF_ERROR;  uses_tag = 1'b1;
         end
         default: begin end
      endcase
   end

   always_comb begin
      ctx_next = ctx;
      ok       = 1'b0;
      rsp      = '0;
      rsp.reason_code = RC_INVALID;
      rtag     = '0;
      unique case (op) inside
         OP_BEGIN: begin
            if (gid == '0) begin
               rsp.reason_code = RC_ID_EMPTY;
            end else if (goal_in_flight(prev)) begin
               rsp.reason_code = RC_ALREADY_ACTIVE;
            end else begin
               ok                  = 1'b1;
               ctx_next.held_id    = gid;
               ctx_next.seq        = ctx.seq + SEQ_BITS'(1);
               ctx_next.life_state = ST_WAITING;
               rsp.reason_code     = RC_GOAL_RECEIVED;
            end
         end
         OP_RESET: begin
            if (prev == ST_IDLE) begin
               ok              = 1'b1;
               rsp.reason_code = RC_ALREADY_IDLE;
            end else if (!goal_finished(prev)) begin
               rsp.reason_code = RC_NO_RESET;
            end else begin
               ok                  = 1'b1;
               ctx_next.life_state = ST_IDLE;
               ctx_next.held_id    = '0;
               rsp.reason_code     = RC_IDLE;
            end
         end
         OP_SERVER_AVAILABLE, OP_ACCEPTED, OP_EXECUTING, OP_CANCEL, OP_SUCCEEDED,
         OP_REJECTED, OP_ABORTED, OP_CANCELED, OP_TIMED_OUT, OP_ERROR: begin
            if (op == OP_CANCEL && (prev == ST_WAITING || prev == ST_SENDING)) begin
               if (step_allowed(prev, ST_CANCELED)) begin
                  ok                  = 1'b1;
                  ctx_next.life_state = ST_CANCELED;
                  rsp.reason_code     = RC_CANCEL_BEFORE;
               end
            end else if (step_allowed(prev, target)) begin
               ok                  = 1'b1;
               ctx_next.life_state = target;
               if (uses_tag && caller_reason != '0) begin
                  rsp.reason_code = RC_TAG;
                  rtag            = caller_reason;
               end else begin
                  rsp.reason_code = code;
               end
            end
         end
         default: begin end
      endcase

      keep_reason = (op == OP_RESET) && (prev == ST_IDLE);
      if (ok && !keep_reason) begin
         ctx_next.last_code = reason_type'(rsp.reason_code);
         ctx_next.last_tag  = rtag;
      end

      rsp.accepted_ok     = ok;
      rsp.prev_state      = prev;
      rsp.new_state       = ctx_next.life_state;
      rsp.current_goal_id = ctx_next.held_id;
      rsp.goal_sequence   = ctx_next.seq;
      rsp.reason_tag      = rtag;
   end

endmodule

// ----- test/goal_handoff_lifecycle_fsm_top_tb.sv -----
module goal_handoff_lifecycle_fsm_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ghl_pkg::*;

   localparam int          RANDOM_EVENTS = 1875;
   localparam int          DRAIN_EVERY   = 400;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          MAX_REPORTS   = 40;
   localparam logic [3:0]  OP_SPARE_LOW  = 4'd12;
   localparam logic [3:0]  OP_SPARE_HIGH = 4'd15;

   typedef struct packed {
      logic           ok;
      life_state_type prev;
      life_state_type next;
      logic [31:0]    goal_id;
      logic [63:0]    seq;
      reason_type     code;
      logic [7:0]     tag;
   } step_result_type;

   // pinned rows carry a hand-written ok / next state / reason code
   typedef struct packed {
      logic [3:0]     op;
      logic [31:0]    goal_id;
      logic [7:0]     tag;
      logic           pinned;
      logic           ok;
      life_state_type next;
      reason_type     code;
   } lifecycle_event_type;

   localparam lifecycle_event_type DIRECTED [26] = '{
      '{OP_RESET,            32'h0000_0000, 8'h00, 1'b1, 1'b1, ST_IDLE,      RC_ALREADY_IDLE},
      '{OP_BEGIN,            32'h0000_0000, 8'h3C, 1'b1, 1'b0, ST_IDLE,      RC_ID_EMPTY},
      '{OP_BEGIN,            32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, ST_WAITING,   RC_GOAL_RECEIVED},
      '{OP_BEGIN,            32'h0000_0001, 8'h00, 1'b1, 1'b0, ST_WAITING,   RC_ALREADY_ACTIVE},
      '{OP_RESET,            32'h0000_0000, 8'h00, 1'b1, 1'b0, ST_WAITING,   RC_NO_RESET},
      '{OP_SERVER_AVAILABLE, 32'h0000_0000, 8'hFF, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_CANCEL,           32'h0000_0000, 8'h55, 1'b1, 1'b1, ST_CANCELED,  RC_CANCEL_BEFORE},
      '{OP_RESET,            32'h0000_0000, 8'h00, 1'b1, 1'b1, ST_IDLE,      RC_IDLE},
      '{OP_BEGIN,            32'h0000_0001, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_SERVER_AVAILABLE, 32'h0000_0000, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_ACCEPTED,         32'h0000_0000, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_EXECUTING,        32'h0000_0000, 8'h01, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_CANCEL,           32'h0000_0000, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_CANCEL,           32'h0000_0000, 8'hAA, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_SUCCEEDED,        32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_SPARE_LOW,        32'h0000_0000, 8'h00, 1'b1, 1'b0, ST_SUCCEEDED, RC_INVALID},
      '{OP_SPARE_HIGH,       32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, ST_SUCCEEDED, RC_INVALID},
      '{OP_BEGIN,            32'h8000_0000, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_TIMED_OUT,        32'h0000_0000, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_BEGIN,            32'h1234_5678, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_ERROR,            32'h0000_0000, 8'hFF, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_ABORTED,          32'h0000_0000, 8'h00, 1'b1, 1'b0, ST_ERROR,     RC_INVALID},
      '{OP_RESET,            32'h0000_0000, 8'h00, 1'b1, 1'b1, ST_IDLE,      RC_IDLE},
      '{OP_BEGIN,            32'h0000_0007, 8'h00, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_REJECTED,         32'h0000_0000, 8'h01, 1'b0, 1'b0, ST_IDLE,      RC_TAG},
      '{OP_CANCELED,         32'h0000_0000, 8'h00, 1'b1, 1'b0, ST_REJECTED,  RC_INVALID}
   };

   logic clock = 1'b0;
   logic reset;

   ghl_req_if req_bus ();
   ghl_rsp_if rsp_bus ();

   goal_handoff_lifecycle_fsm_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted lifecycle state
   life_state_type life_now   = ST_IDLE;
   logic [31:0]    stored_id  = '0;
   logic [63:0]    goal_count = '0;

   step_result_type awaited_steps [$];

   int mismatches    = 0;
   int events_sent   = 0;
   int goals_begun   = 0;
   int refused_steps = 0;
   int terminal_hits = 0;
   int burst_left    = 0;
   int cycle_count;

   function automatic logic step_legal(life_state_type from_st, life_state_type to_st);
      if (from_st == to_st)
         return 1'b1;
      case (from_st)
         ST_IDLE:      return to_st inside {ST_WAITING, ST_ERROR};
         ST_WAITING:   return to_st inside {ST_SENDING, ST_REJECTED, ST_CANCELED,
                                            ST_TIMED_OUT, ST_ERROR};
         ST_SENDING:   return to_st inside {ST_ACCEPTED, ST_REJECTED, ST_CANCELED,
                                            ST_TIMED_OUT, ST_ERROR};
         ST_ACCEPTED:  return to_st inside {ST_EXECUTING, ST_CANCELING, ST_SUCCEEDED,
                                            ST_ABORTED, ST_CANCELED, ST_TIMED_OUT, ST_ERROR};
         ST_EXECUTING: return to_st inside {ST_CANCELING, ST_SUCCEEDED, ST_ABORTED,
                                            ST_CANCELED, ST_TIMED_OUT, ST_ERROR};
         ST_CANCELING: return to_st inside {ST_SUCCEEDED, ST_CANCELED, ST_ABORTED,
                                            ST_TIMED_OUT, ST_ERROR};
         default:      return to_st inside {ST_WAITING, ST_IDLE};
      endcase
   endfunction

   function automatic step_result_type apply_event(logic [3:0] op, logic [31:0] id,
                                                   logic [7:0] tag);
      step_result_type r;
      life_state_type  target;
      reason_type      code;
      logic [7:0]      rtag;
      logic            ok;
      logic            carries_tag;
      r.prev = life_now;
      ok     = 1'b0;
      code   = RC_INVALID;
      rtag   = '0;
      target = ST_IDLE;
      if (op == OP_BEGIN) begin
         if (id == '0) begin
            code = RC_ID_EMPTY;
         end else if (life_now inside {[ST_WAITING:ST_CANCELING]}) begin
            code = RC_ALREADY_ACTIVE;
         end else begin
            stored_id  = id;
            goal_count = goal_count + 64'd1;
            life_now   = ST_WAITING;
            ok         = 1'b1;
            code       = RC_GOAL_RECEIVED;
         end
      end else if (op == OP_RESET) begin
         if (life_now == ST_IDLE) begin
            ok   = 1'b1;
            code = RC_ALREADY_IDLE;
         end else if (!(life_now inside {[ST_SUCCEEDED:ST_ERROR]})) begin
            code = RC_NO_RESET;
         end else begin
            life_now  = ST_IDLE;
            stored_id = '0;
            ok        = 1'b1;
            code      = RC_IDLE;
         end
      end else if (op <= OP_ERROR) begin
         case (op)
            OP_SERVER_AVAILABLE: begin target = ST_SENDING;   code = RC_SERVER_AVAILABLE; end
            OP_ACCEPTED:         begin target = ST_ACCEPTED;  code = RC_GOAL_ACCEPTED;    end
            OP_EXECUTING:        begin target = ST_EXECUTING; code = RC_GOAL_EXECUTING;   end
            OP_CANCEL:           begin target = ST_CANCELING; code = RC_CANCEL_REQUESTED; end
            OP_SUCCEEDED:        begin target = ST_SUCCEEDED; code = RC_GOAL_SUCCEEDED;   end
            OP_REJECTED:         begin target = ST_REJECTED;  code = RC_GOAL_REJECTED;    end
            OP_ABORTED:          begin target = ST_ABORTED;   code = RC_GOAL_ABORTED;     end
            OP_CANCELED:         begin target = ST_CANCELED;  code = RC_GOAL_CANCELED;    end
            OP_TIMED_OUT:        begin target = ST_TIMED_OUT; code = RC_GOAL_TIMED_OUT;   end
            default:             begin target = ST_ERROR;     code = RC_HANDOFF_ERROR;    end
         endcase
         carries_tag = (op == OP_CANCEL) || (op >= OP_REJECTED);
         if (carries_tag && tag != '0) begin
            code = RC_TAG;
            rtag = tag;
         end
         // cancel before acceptance goes straight to canceled
         if (op == OP_CANCEL && life_now inside {ST_WAITING, ST_SENDING}) begin
            target = ST_CANCELED;
            code   = RC_CANCEL_BEFORE;
            rtag   = '0;
         end
         if (step_legal(life_now, target)) begin
            life_now = target;
            ok       = 1'b1;
         end else begin
            code = RC_INVALID;
            rtag = '0;
         end
      end
      r.ok      = ok;
      r.next    = life_now;
      r.goal_id = stored_id;
      r.seq     = goal_count;
      r.code    = code;
      r.tag     = ok ? rtag : 8'h00;
      return r;
   endfunction

   task automatic idle_before_event(input bit drain);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0 || (drain && awaited_steps.size() != 0)) begin
         req_bus.valid <= 1'b0;
         while (drain && awaited_steps.size() != 0)
            @(posedge clock);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_event(input lifecycle_event_type ev);
      step_result_type r;
      req_bus.valid         <= 1'b1;
      req_bus.op            <= ev.op;
      req_bus.goal_id       <= ev.goal_id;
      req_bus.caller_reason <= ev.tag;
      do
         @(posedge clock);
      while (!req_bus.ready);
      r = apply_event(ev.op, ev.goal_id, ev.tag);
      if (ev.pinned) begin
         r.ok   = ev.ok;
         r.next = ev.next;
         r.code = ev.code;
      end
      awaited_steps.push_back(r);
      events_sent++;
      if (!r.ok)
         refused_steps++;
      else if (ev.op == OP_BEGIN)
         goals_begun++;
      if (r.ok && r.next != r.prev && r.next inside {[ST_SUCCEEDED:ST_ERROR]})
         terminal_hits++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
      end
   endtask

   task automatic check_result();
      step_result_type want;
      if (awaited_steps.size() == 0) begin
         mismatches++;
         $display({"%0d ns: result transaction with no event pending, expected none, ",
                   "actual state %0d->%0d code %0d"},
                  $time, rsp_bus.prev_state, rsp_bus.new_state, rsp_bus.reason_code);
      end else begin
         want = awaited_steps.pop_front();
         check_field("accepted_ok",     want.ok,      rsp_bus.accepted_ok);
         check_field("prev_state",      want.prev,    rsp_bus.prev_state);
         check_field("new_state",       want.next,    rsp_bus.new_state);
         check_field("current_goal_id", want.goal_id, rsp_bus.current_goal_id);
         check_field("goal_sequence",   want.seq,     rsp_bus.goal_sequence);
         check_field("reason_code",     want.code,    rsp_bus.reason_code);
         check_field("reason_tag",      want.tag,     rsp_bus.reason_tag);
      end
   endtask

   // receiver: checks results and stalls in modes that change over time
   initial begin
      int stall_mode;
      int mode_left;
      int stall_phase;
      stall_mode  = 0;
      mode_left   = 0;
      stall_phase = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(30, 200);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 9) < 6);
            2:       rsp_bus.ready <= (stall_phase % 4 == 0);
            default: rsp_bus.ready <= (stall_phase % 16 >= 10);
         endcase
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("Timeout after %0d cycles, %0d results still pending",
               CYCLE_LIMIT, awaited_steps.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      lifecycle_event_type ev;
      op_type              opts [10];
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.op            <= '0;
      req_bus.goal_id       <= '0;
      req_bus.caller_reason <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         idle_before_event(1'b0);
         send_event(DIRECTED[i]);
      end

      for (int i = 0; i < RANDOM_EVENTS; i++) begin
         idle_before_event(i % DRAIN_EVERY == 0);
         if ($urandom_range(0, 99) < 15) begin
            ev.op = 4'($urandom_range(0, 15));
         end else begin
            // mostly walk the goal through a plausible lifecycle
            case (life_now)
               ST_IDLE:      opts = '{OP_BEGIN, OP_BEGIN, OP_BEGIN, OP_BEGIN, OP_BEGIN,
                                      OP_BEGIN, OP_BEGIN, OP_BEGIN, OP_RESET, OP_ERROR};
               ST_WAITING:   opts = '{OP_SERVER_AVAILABLE, OP_SERVER_AVAILABLE,
                                      OP_SERVER_AVAILABLE, OP_SERVER_AVAILABLE,
                                      OP_SERVER_AVAILABLE, OP_SERVER_AVAILABLE,
                                      OP_CANCEL, OP_REJECTED, OP_TIMED_OUT, OP_ERROR};
               ST_SENDING:   opts = '{OP_ACCEPTED, OP_ACCEPTED, OP_ACCEPTED, OP_ACCEPTED,
                                      OP_ACCEPTED, OP_ACCEPTED, OP_CANCEL, OP_REJECTED,
                                      OP_CANCELED, OP_TIMED_OUT};
               ST_ACCEPTED:  opts = '{OP_EXECUTING, OP_EXECUTING, OP_EXECUTING,
                                      OP_EXECUTING, OP_EXECUTING, OP_EXECUTING,
                                      OP_CANCEL, OP_SUCCEEDED, OP_ABORTED, OP_CANCELED};
               ST_EXECUTING: opts = '{OP_SUCCEEDED, OP_SUCCEEDED, OP_SUCCEEDED,
                                      OP_SUCCEEDED, OP_CANCEL, OP_CANCEL, OP_ABORTED,
                                      OP_CANCELED, OP_TIMED_OUT, OP_ERROR};
               ST_CANCELING: opts = '{OP_CANCELED, OP_CANCELED, OP_CANCELED, OP_CANCELED,
                                      OP_CANCELED, OP_SUCCEEDED, OP_ABORTED,
                                      OP_TIMED_OUT, OP_ERROR, OP_CANCEL};
               default:      opts = '{OP_BEGIN, OP_BEGIN, OP_BEGIN, OP_BEGIN, OP_BEGIN,
                                      OP_RESET, OP_RESET, OP_RESET, OP_RESET, OP_RESET};
            endcase
            ev.op = opts[$urandom_range(0, 9)];
         end
         case ($urandom_range(0, 15))
            0:       ev.goal_id = '0;
            1:       ev.goal_id = '1;
            default: ev.goal_id = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0, 1, 2: ev.tag = '0;
            3:       ev.tag = '1;
            default: ev.tag = 8'($urandom_range(1, 255));
         endcase
         ev.pinned = 1'b0;
         ev.ok     = 1'b0;
         ev.next   = ST_IDLE;
         ev.code   = RC_TAG;
         send_event(ev);
      end

      req_bus.valid <= 1'b0;
      while (awaited_steps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d lifecycle events: %0d goals begun, %0d steps refused, %0d terminal entries",
               events_sent, goals_begun, refused_steps, terminal_hits);
      $display("Directed extremes, spare ops and random lifecycles with sender bursts and receiver stalls");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ghl_pkg.sv
rtl/ghl_req_if.sv
rtl/ghl_rsp_if.sv
rtl/ghl_step.sv
rtl/goal_handoff_lifecycle_fsm_top.sv
test/goal_handoff_lifecycle_fsm_top_tb.sv
